// ===== rtl/rldr_pkg.sv =====
// shared types and constants for the radial lens distortion remap unit
package rldr_pkg;

	localparam int COORD_W = 12;
	localparam int DIM_W   = 13;
	localparam int CTR_W   = 16;
	localparam int K_W     = 16;
	localparam int INV_W   = 32;
	localparam int OFS_W   = 18;
	localparam int D2_W    = 33;
	localparam int R2_W    = 24;
	localparam int R4_W    = 32;
	localparam int F_W     = 32;
	localparam int Q_W     = 33;
	localparam int DIV_STEPS = Q_W;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic signed [F_W-1:0] F_MAX = {1'b0, {(F_W-1){1'b1}}};
	localparam logic signed [F_W-1:0] F_MIN = {1'b1, {(F_W-1){1'b0}}};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH   = 3'd0,
		REG_FRAME_HEIGHT  = 3'd1,
		REG_CENTER_X      = 3'd2,
		REG_CENTER_Y      = 3'd3,
		REG_STRENGTH      = 3'd4,
		REG_INV_RADIUS_SQ = 3'd5,
		REG_REVERSE       = 3'd6,
		REG_UNUSED        = 3'd7
	} cfg_reg_t;

	// what travels alongside the arithmetic down the pipe
	typedef struct packed {
		logic                    ident;
		logic [COORD_W-1:0]      px;
		logic [COORD_W-1:0]      py;
		logic signed [OFS_W-1:0] dx;
		logic signed [OFS_W-1:0] dy;
		logic signed [F_W-1:0]   f;
	} side_t;

endpackage

// ===== rtl/rldr_if.sv =====
// handshake channels for pixel coordinates in and source coordinates out
interface rldr_pixel_if;
	import rldr_pkg::*;
	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] pixel_x;
	logic [COORD_W-1:0] pixel_y;
	modport source (output valid, output pixel_x, output pixel_y, input ready);
	modport sink (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface rldr_source_if;
	import rldr_pkg::*;
	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] source_x;
	logic [COORD_W-1:0] source_y;
	modport source (output valid, output source_x, output source_y, input ready);
	modport sink (input valid, input source_x, input source_y, output ready);
endinterface

// ===== rtl/rldr_factor.sv =====
// offset, squared radius and distortion factor pipeline (seven stages)
module rldr_factor #(
	parameter int STRENGTH_FRAC_BITS = 14
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   en,
	input  logic                                   in_valid,
	input  logic [rldr_pkg::COORD_W-1:0]           px,
	input  logic [rldr_pkg::COORD_W-1:0]           py,
	input  logic [rldr_pkg::CTR_W-1:0]             cx,
	input  logic [rldr_pkg::CTR_W-1:0]             cy,
	input  logic signed [rldr_pkg::K_W-1:0]        k,
	input  logic [rldr_pkg::INV_W-1:0]             inv,
	output logic                                   out_valid,
	output rldr_pkg::side_t                        out_side
);
	import rldr_pkg::*;

	localparam int AK_W   = K_W + 1;
	localparam int AKM_W  = AK_W + 10;
	localparam int PP_W   = D2_W + INV_W/2;
	localparam int KR2_W  = K_W + R2_W + 1;
	localparam int KR4_W  = K_W + R4_W + 1;
	localparam int SUM_W  = KR4_W + 1;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	side_t side_s1, side_s2, side_s3, side_s4, side_s5, side_s6, side_s7;
	logic [D2_W-1:0] d2_s2;
	logic [PP_W-1:0] pa_s3, pb_s3;
	logic [R2_W-1:0] r2_s4;
	logic signed [KR2_W-1:0] kr2_s5, t1_s6;
	logic [R4_W-1:0] r4_s5;
	logic signed [KR4_W-1:0] kr4_s6;

	logic [AK_W-1:0] ak;
	logic [AKM_W-1:0] akm;
	side_t side_in;
	side_t side_f;
	logic signed [2*OFS_W-1:0] sqx, sqy;
	logic [PP_W:0] psum;
	logic [PP_W-8:0] rfull;
	logic [2*R2_W-1:0] r2sq;
	logic signed [SUM_W-1:0] fsum;

	always_comb begin
		ak = k[K_W-1] ? AK_W'(-$signed({k[K_W-1], k})) : AK_W'({1'b0, k});
		akm = AKM_W'(ak) * AKM_W'(1000);
		side_in.ident = akm < (AKM_W'(1) << STRENGTH_FRAC_BITS);
		side_in.px = px;
		side_in.py = py;
		side_in.dx = $signed({2'b00, px, 4'b0000}) - $signed({2'b00, cx});
		side_in.dy = $signed({2'b00, py, 4'b0000}) - $signed({2'b00, cy});
		side_in.f = '0;
		sqx = side_s1.dx * side_s1.dx;
		sqy = side_s1.dy * side_s1.dy;
		psum = {1'b0, pa_s3} + (PP_W+1)'(pb_s3 >> 16);
		rfull = psum[PP_W:8];
		r2sq = r2_s4 * r2_s4;
		fsum = SUM_W'(65536) + SUM_W'(t1_s6) + SUM_W'(kr4_s6 >>> (STRENGTH_FRAC_BITS + 1));
		side_f = side_s6;
		if (fsum > SUM_W'(F_MAX))
			side_f.f = F_MAX;
		else if (fsum < SUM_W'(F_MIN))
			side_f.f = F_MIN;
		else
			side_f.f = fsum[F_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side_in;
			side_s2 <= side_s1;
			side_s3 <= side_s2;
			side_s4 <= side_s3;
			side_s5 <= side_s4;
			side_s6 <= side_s5;
			d2_s2 <= {1'b0, sqx[D2_W-2:0]} + {1'b0, sqy[D2_W-2:0]};
			// 33 x 32 product split into two 33 x 16 halves
			pa_s3 <= d2_s2 * inv[INV_W-1:INV_W/2];
			pb_s3 <= d2_s2 * inv[INV_W/2-1:0];
			r2_s4 <= (rfull > (PP_W-7)'({R2_W{1'b1}})) ? {R2_W{1'b1}} : rfull[R2_W-1:0];
			kr2_s5 <= k * $signed({1'b0, r2_s4});
			r4_s5 <= r2sq[2*R2_W-1:16];
			t1_s6 <= kr2_s5 >>> STRENGTH_FRAC_BITS;
			kr4_s6 <= k * $signed({1'b0, r4_s5});
			side_s7 <= side_f;
		end
	end

	assign out_valid = v_s7;
	assign out_side = side_s7;

endmodule

// ===== rtl/rldr_recip.sv =====
// pipelined restoring divider: 2^32 / |f|, one quotient bit per stage
module rldr_recip (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  rldr_pkg::side_t             in_side,
	output logic                        out_valid,
	output rldr_pkg::side_t             out_side,
	output logic [rldr_pkg::Q_W-1:0]    quot
);
	import rldr_pkg::*;

	logic              v_s   [DIV_STEPS];
	side_t             side_s[DIV_STEPS];
	logic [F_W-1:0]    div_s [DIV_STEPS];
	logic [Q_W-1:0]    rem_s [DIV_STEPS];
	logic [Q_W-1:0]    q_s   [DIV_STEPS];
	logic [F_W-1:0]    div_in;

	assign div_in = in_side.f[F_W-1] ? F_W'(-in_side.f) : F_W'(in_side.f);

	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
		logic          v_prev;
		side_t         side_prev;
		logic [F_W-1:0] div_prev;
		logic [Q_W-1:0] rem_prev, q_prev, shifted;
		logic           take;

		if (i == 0) begin : g_first
			assign v_prev = in_valid;
			assign side_prev = in_side;
			assign div_prev = div_in;
			assign rem_prev = '0;
			assign q_prev = '0;
		end else begin : g_next
			assign v_prev = v_s[i-1];
			assign side_prev = side_s[i-1];
			assign div_prev = div_s[i-1];
			assign rem_prev = rem_s[i-1];
			assign q_prev = q_s[i-1];
		end

		// dividend is a single one at its top bit
		assign shifted = {rem_prev[Q_W-2:0], (i == 0) ? 1'b1 : 1'b0};
		assign take = shifted >= {1'b0, div_prev};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[i] <= 1'b0;
			else if (en)
				v_s[i] <= v_prev;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[i] <= side_prev;
				div_s[i] <= div_prev;
				rem_s[i] <= take ? shifted - {1'b0, div_prev} : shifted;
				q_s[i] <= {q_prev[Q_W-2:0], take};
			end
		end
	end

	assign out_valid = v_s[DIV_STEPS-1];
	assign out_side = side_s[DIV_STEPS-1];
	assign quot = q_s[DIV_STEPS-1];

endmodule

// ===== rtl/rldr_map.sv =====
// factor select, offset scaling and frame clamp (three stages)
module rldr_map (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           in_valid,
	input  rldr_pkg::side_t                in_side,
	input  logic [rldr_pkg::Q_W-1:0]       quot,
	input  logic                           reverse,
	input  logic [rldr_pkg::CTR_W-1:0]     cx,
	input  logic [rldr_pkg::CTR_W-1:0]     cy,
	input  logic [rldr_pkg::COORD_W-1:0]   hx,
	input  logic [rldr_pkg::COORD_W-1:0]   hy,
	output logic                           out_valid,
	output logic [rldr_pkg::COORD_W-1:0]   sx,
	output logic [rldr_pkg::COORD_W-1:0]   sy
);
	import rldr_pkg::*;

	localparam int P_W = OFS_W + F_W;
	localparam int S_W = P_W + 1;
	localparam int T_W = S_W - 20;

	logic v_s1, v_s2, v_s3;
	side_t side_s1, side_s2;
	logic signed [F_W-1:0] g_s1;
	logic signed [P_W-1:0] prx_s2, pry_s2;
	logic [COORD_W-1:0] sx_s3, sy_s3;

	logic signed [F_W-1:0] g;
	logic signed [S_W-1:0] accx, accy;
	logic [COORD_W-1:0] mx, my;

	function automatic logic [COORD_W-1:0] clamp_src(input logic signed [S_W-1:0] s,
			input logic [COORD_W-1:0] hi);
		logic [T_W-1:0] t;
		t = s[S_W-1:20];
		if (s[S_W-1])
			return '0;
		else if (t > T_W'(hi))
			return hi;
		else
			return t[COORD_W-1:0];
	endfunction

	always_comb begin
		if (!reverse)
			g = in_side.f;
		else if (in_side.f == '0)
			g = F_MAX;
		else if (in_side.f[F_W-1])
			g = (quot > Q_W'({1'b1, {(F_W-1){1'b0}}})) ? F_MIN : F_W'(-quot);
		else
			g = (quot > Q_W'(F_MAX)) ? F_MAX : F_W'(quot);
		accx = $signed(S_W'({1'b0, cx, 16'h0000})) + S_W'(prx_s2);
		accy = $signed(S_W'({1'b0, cy, 16'h0000})) + S_W'(pry_s2);
		mx = side_s2.ident ? ((side_s2.px > hx) ? hx : side_s2.px) : clamp_src(accx, hx);
		my = side_s2.ident ? ((side_s2.py > hy) ? hy : side_s2.py) : clamp_src(accy, hy);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= in_side;
			g_s1 <= g;
			side_s2 <= side_s1;
			prx_s2 <= side_s1.dx * g_s1;
			pry_s2 <= side_s1.dy * g_s1;
			sx_s3 <= mx;
			sy_s3 <= my;
		end
	end

	assign out_valid = v_s3;
	assign sx = sx_s3;
	assign sy = sy_s3;

endmodule

// ===== rtl/radial_lens_distortion_remap_unit.sv =====
// top level of the radial lens distortion coordinate remap
//
// channel   dir  payload               beat when
// pixel     in   pixel_x, pixel_y      pixel.valid & pixel.ready
// source    out  source_x, source_y    source.valid & source.ready
// cfg_*     in   cfg_index, cfg_data   cfg_we
//
// one beat per clock in and out while the pipe advances; the pipe has 7 factor stages,
// 33 divider stages (one quotient bit each) and 3 mapping stages.
// the whole pipe advances together; it halts only when the output register
// holds a beat the sink has not taken, so nothing is dropped or repeated.
// arst_n clears all valid bits and loads the register defaults.
module radial_lens_distortion_remap_unit #(
	parameter int MAX_DIM = 4096,
	parameter int STRENGTH_FRAC_BITS = 14
) (
	input  logic                              clk,
	input  logic                              arst_n,
	rldr_pixel_if.sink                        pixel,
	rldr_source_if.source                     source,
	input  logic                              cfg_we,
	input  logic [rldr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rldr_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import rldr_pkg::*;

	localparam int LIM = (MAX_DIM > 4096) ? 4096 : MAX_DIM;

	logic [DIM_W-1:0] frame_width_q, frame_height_q;
	logic [CTR_W-1:0] center_x_q, center_y_q;
	logic signed [K_W-1:0] strength_q;
	logic [INV_W-1:0] inv_radius_sq_q;
	logic reverse_q;

	logic en;
	logic f_valid, r_valid;
	side_t f_side, r_side;
	logic [Q_W-1:0] quot;
	logic [COORD_W-1:0] hx, hy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q <= DIM_W'(1920);
			frame_height_q <= DIM_W'(1080);
			center_x_q <= CTR_W'(15360);
			center_y_q <= CTR_W'(8640);
			strength_q <= '0;
			inv_radius_sq_q <= INV_W'(3544);
			reverse_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_FRAME_WIDTH:   frame_width_q <= cfg_data[DIM_W-1:0];
				REG_FRAME_HEIGHT:  frame_height_q <= cfg_data[DIM_W-1:0];
				REG_CENTER_X:      center_x_q <= cfg_data[CTR_W-1:0];
				REG_CENTER_Y:      center_y_q <= cfg_data[CTR_W-1:0];
				REG_STRENGTH:      strength_q <= cfg_data[K_W-1:0];
				REG_INV_RADIUS_SQ: inv_radius_sq_q <= cfg_data[INV_W-1:0];
				REG_REVERSE:       reverse_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	function automatic logic [COORD_W-1:0] bound_of(input logic [DIM_W-1:0] size);
		logic [DIM_W-1:0] b;
		b = (size > DIM_W'(LIM)) ? DIM_W'(LIM) : size;
		if (b == '0)
			return '0;
		else
			return COORD_W'(b - DIM_W'(1));
	endfunction

	assign hx = bound_of(frame_width_q);
	assign hy = bound_of(frame_height_q);

	// advance unless the output register holds an untaken beat
	assign en = !source.valid || source.ready;
	assign pixel.ready = en;

	rldr_factor #(
		.STRENGTH_FRAC_BITS(STRENGTH_FRAC_BITS)
	) u_factor (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (pixel.valid),
		.px       (pixel.pixel_x),
		.py       (pixel.pixel_y),
		.cx       (center_x_q),
		.cy       (center_y_q),
		.k        (strength_q),
		.inv      (inv_radius_sq_q),
		.out_valid(f_valid),
		.out_side (f_side)
	);

	rldr_recip u_recip (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (f_valid),
		.in_side  (f_side),
		.out_valid(r_valid),
		.out_side (r_side),
		.quot     (quot)
	);

	rldr_map u_map (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (r_valid),
		.in_side  (r_side),
		.quot     (quot),
		.reverse  (reverse_q),
		.cx       (center_x_q),
		.cy       (center_y_q),
		.hx       (hx),
		.hy       (hy),
		.out_valid(source.valid),
		.sx       (source.source_x),
		.sy       (source.source_y)
	);

endmodule

// ===== bench/tb_radial_lens_distortion_remap_unit.sv =====
// self-checking bench for the radial lens distortion remap unit
`timescale 1ns / 100ps

module tb_radial_lens_distortion_remap_unit;
	import rldr_pkg::*;

	localparam longint F_HI = 64'sd2147483647;
	localparam longint F_LO = -64'sd2147483648;

	typedef struct {
		logic [COORD_W-1:0] sx;
		logic [COORD_W-1:0] sy;
	} src_pos_t;

	// register shadow and source coordinate predictor
	class remap_scoreboard;
		logic [DIM_W-1:0] fw = 13'd1920;
		logic [DIM_W-1:0] fh = 13'd1080;
		logic [CTR_W-1:0] cx = 16'd15360;
		logic [CTR_W-1:0] cy = 16'd8640;
		logic [K_W-1:0]   kq = '0;
		logic [INV_W-1:0] inv = 32'd3544;
		logic             rev = 1'b0;
		src_pos_t         pending[$];
		int               errors = 0;

		function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] v);
			case (idx)
				REG_FRAME_WIDTH: fw = v[DIM_W-1:0];
				REG_FRAME_HEIGHT: fh = v[DIM_W-1:0];
				REG_CENTER_X: cx = v[CTR_W-1:0];
				REG_CENTER_Y: cy = v[CTR_W-1:0];
				REG_STRENGTH: kq = v[K_W-1:0];
				REG_INV_RADIUS_SQ: inv = v;
				REG_REVERSE: rev = v[0];
				default: ;
			endcase
		endfunction

		function longint bound(logic [DIM_W-1:0] sz);
			longint b;
			b = sz;
			if (b > 4096) b = 4096;
			if (b == 0) return 0;
			return b - 1;
		endfunction

		function longint clampv(longint v, longint hi);
			if (v < 0) return 0;
			if (v > hi) return hi;
			return v;
		endfunction

		function longint floor_sh(longint v, int s);
			return v >>> s;
		endfunction

		function longint axis(longint c, longint d, longint f, longint hi);
			longint s;
			s = c * 65536 + d * f;
			if (s < 0) return 0;
			return clampv(s >>> 20, hi);
		endfunction

		function void note_pixel(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py);
			longint hx, hy, k, ak, dx, dy, f, d2, r2, r4;
			src_pos_t e;
			hx = bound(fw);
			hy = bound(fh);
			k = longint'($signed(kq));
			ak = k < 0 ? -k : k;
			if (ak * 1000 < 16384) begin
				e.sx = COORD_W'(clampv(px, hx));
				e.sy = COORD_W'(clampv(py, hy));
			end else begin
				dx = longint'(px) * 16 - longint'(cx);
				dy = longint'(py) * 16 - longint'(cy);
				d2 = dx * dx + dy * dy;
				r2 = (d2 * longint'(inv[31:16]) + ((d2 * longint'(inv[15:0])) >>> 16)) >>> 8;
				if (r2 > 64'hFFFFFF) r2 = 64'hFFFFFF;
				r4 = (r2 * r2) >>> 16;
				f = 65536 + floor_sh(k * r2, 14) + floor_sh(k * r4, 15);
				if (f > F_HI) f = F_HI;
				if (f < F_LO) f = F_LO;
				if (rev) begin
					if (f == 0) f = F_HI;
					else begin
						f = (longint'(1) <<< 32) / f;
						if (f > F_HI) f = F_HI;
						if (f < F_LO) f = F_LO;
					end
				end
				e.sx = COORD_W'(axis(cx, dx, f, hx));
				e.sy = COORD_W'(axis(cy, dy, f, hy));
			end
			pending.push_back(e);
		endfunction

		function void check_source(logic [COORD_W-1:0] sx, logic [COORD_W-1:0] sy);
			src_pos_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected beat sx=%0d sy=%0d", $time, sx, sy);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (sx !== e.sx) begin
				$display("%0t: source_x expected %0d actual %0d", $time, e.sx, sx);
				errors++;
			end
			if (sy !== e.sy) begin
				$display("%0t: source_y expected %0d actual %0d", $time, e.sy, sy);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	int send_idle = 0;
	int recv_stall = 0;
	int hold_off = 0;

	rldr_pixel_if pixel ();
	rldr_source_if source ();

	radial_lens_distortion_remap_unit u_dut (
		.clk(clk), .arst_n(arst_n), .pixel(pixel), .source(source),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	remap_scoreboard sb = new();

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("tb_radial_lens_distortion_remap_unit NOT OK");
		$finish;
	end

	initial begin
		pixel.valid = 1'b0;
		pixel.pixel_x = '0;
		pixel.pixel_y = '0;
	end

	// sink side: random stall plus an optional long hold-off
	initial begin
		source.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off > 0) begin
				source.ready <= 1'b0;
				hold_off--;
			end else
				source.ready <= ($urandom_range(99) >= recv_stall);
		end
	end

	always @(posedge clk) begin
		if (arst_n && source.valid && source.ready)
			sb.check_source(source.source_x, source.source_y);
	end

	// registers change only with the pipe empty
	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] v);
		pixel.valid <= 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		sb.set_reg(idx, v);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_pixel(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py);
		while ($urandom_range(99) < send_idle) begin
			pixel.valid <= 1'b0;
			@(negedge clk);
		end
		pixel.valid <= 1'b1;
		pixel.pixel_x <= px;
		pixel.pixel_y <= py;
		@(posedge clk);
		while (!pixel.ready) @(posedge clk);
		sb.note_pixel(px, py);
		@(negedge clk);
	endtask

	task automatic drain();
		pixel.valid <= 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (50) @(negedge clk);
	endtask

	task automatic random_regs();
		int sel;
		sel = $urandom_range(9);
		write_reg(REG_FRAME_WIDTH, sel == 0 ? 0 : (sel == 1 ? 1 : (sel == 2 ? 8191 :
			(sel < 5 ? 4096 : $urandom_range(8191)))));
		sel = $urandom_range(9);
		write_reg(REG_FRAME_HEIGHT, sel == 0 ? 0 : (sel == 1 ? 1 : (sel == 2 ? 8191 :
			(sel < 5 ? 4096 : $urandom_range(8191)))));
		write_reg(REG_CENTER_X, $urandom_range(65535));
		write_reg(REG_CENTER_Y, $urandom_range(65535));
		sel = $urandom_range(7);
		write_reg(REG_STRENGTH, sel == 0 ? 16'h8000 : (sel == 1 ? 16'h7FFF :
			(sel == 2 ? 16'd16384 : (sel == 3 ? 16'hC000 : (sel == 4 ? 16'd16 :
			$urandom_range(65535))))));
		sel = $urandom_range(7);
		write_reg(REG_INV_RADIUS_SQ, sel == 0 ? 32'hFFFFFFFF : (sel == 1 ? 0 :
			(sel < 4 ? $urandom_range(20000) : $urandom())));
		write_reg(REG_REVERSE, $urandom_range(1));
	endtask

	initial begin
		int idle_s[4] = '{0, 49, 0, 18};
		int idle_r[4] = '{0, 0, 49, 18};
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// directed: corners with defaults, then a strong barrel in both modes
		send_pixel(0, 0);
		send_pixel(4095, 4095);
		send_pixel(960, 540);
		send_pixel(1919, 1079);
		write_reg(REG_STRENGTH, 16'd16); // below the identity threshold
		send_pixel(4095, 0);
		write_reg(REG_STRENGTH, 16'd17);
		send_pixel(0, 4095);
		write_reg(REG_STRENGTH, 16'hC000);
		send_pixel(0, 0);
		send_pixel(4095, 4095);
		write_reg(REG_REVERSE, 1);
		// a strength of -2 with r2 near one drives the factor negative, to about -2
		write_reg(REG_STRENGTH, 16'h8000);
		write_reg(REG_CENTER_X, 0);
		write_reg(REG_CENTER_Y, 0);
		write_reg(REG_INV_RADIUS_SQ, 32'hFFFFFFFF);
		send_pixel(0, 0);
		send_pixel(1, 0);
		send_pixel(4095, 4095);
		write_reg(REG_STRENGTH, 16'h7FFF);
		send_pixel(2048, 1024);
		write_reg(REG_FRAME_WIDTH, 0);
		write_reg(REG_FRAME_HEIGHT, 8191);
		send_pixel(4095, 4095);
		drain();

		// long receiver hold-off while the sender keeps pushing
		hold_off = 300;
		for (int i = 0; i < 80; i++) send_pixel(COORD_W'($urandom()), COORD_W'($urandom()));
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			send_idle = idle_s[ph % 4];
			recv_stall = idle_r[ph % 4];
			random_regs();
			for (int i = 0; i < 115; i++) begin
				if ($urandom_range(3) == 0)
					send_pixel(COORD_W'($urandom()), COORD_W'($urandom()));
				else
					send_pixel(COORD_W'($urandom_range(2047)),
						COORD_W'($urandom_range(1279)));
			end
			drain();
		end

		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("tb_radial_lens_distortion_remap_unit OK");
		else
			$display("tb_radial_lens_distortion_remap_unit NOT OK");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/rldr_pkg.sv
rtl/rldr_if.sv
rtl/rldr_factor.sv
rtl/rldr_recip.sv
rtl/rldr_map.sv
rtl/radial_lens_distortion_remap_unit.sv
bench/tb_radial_lens_distortion_remap_unit.sv
